FILE: src/sm4_block_cipher_defines.svh
// assertion macros for the sm4 block cipher
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication
`define SM4_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sm4 check failed");

// next-cycle implication
`define SM4_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sm4 check failed");

`endif

FILE: src/sm4_pkg.sv
package sm4_pkg;

	localparam int ROUND_COUNT = 32;
	localparam int RK_AW = $clog2(ROUND_COUNT);
	localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(ROUND_COUNT - 1);
	localparam int KEY_IDX_W = 2;

	localparam logic [31:0] FK [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
		8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
		8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
		8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
		8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
		8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
		8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
		8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
		8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
		8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
		8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
		8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
		8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
		8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
		8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
		8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
		8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
		8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
		8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
		8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
		8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
		8'hD7, 8'hCB, 8'h39, 8'h48
	};

	typedef struct packed {
		logic             cfg_we;
		logic             load_key;
		logic             load_blk;
		logic             round_en;
		logic             key_mode;
		logic             out_load;
		logic [RK_AW-1:0] round;
	} sm4_cmd_t;

	typedef struct packed {
		logic out_free;
	} sm4_stat_t;

	// ck byte j of round i is (4*i + j) * 7 mod 256
	function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] round);
		logic [31:0] w;
		logic [7:0]  b;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			b = 8'({round, 2'(j)}) * 8'd7;
			w[31-8*j -: 8] = b;
		end
		return w;
	endfunction

	function automatic logic [31:0] tau(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] lin_data(input logic [31:0] b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

endpackage

FILE: src/sm4_if.sv
interface sm4_in_if;
	logic        valid;
	logic        ready;
	logic        decrypt;
	logic [31:0] in_word0;
	logic [31:0] in_word1;
	logic [31:0] in_word2;
	logic [31:0] in_word3;

	modport source(output valid, decrypt, in_word0, in_word1, in_word2, in_word3,
		input ready);
	modport sink(input valid, decrypt, in_word0, in_word1, in_word2, in_word3,
		output ready);
endinterface

interface sm4_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word0;
	logic [31:0] out_word1;
	logic [31:0] out_word2;
	logic [31:0] out_word3;

	modport source(output valid, out_word0, out_word1, out_word2, out_word3,
		input ready);
	modport sink(input valid, out_word0, out_word1, out_word2, out_word3,
		output ready);
endinterface

interface sm4_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sm4_pkg::KEY_IDX_W-1:0]  index;
	logic [31:0]                    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/sm4_ram.sv
module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/sm4_ctrl.sv
module sm4_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  sm4_pkg::sm4_stat_t stat,
	output sm4_pkg::sm4_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_KINIT = 5'b00001,
		ST_KEY   = 5'b00010,
		ST_IDLE  = 5'b00100,
		ST_RUN   = 5'b01000,
		ST_WAIT  = 5'b10000
	} state_t;

	state_t                    state_q, state_d;
	logic [sm4_pkg::RK_AW-1:0] round_q, round_d;

	always_comb begin
		state_d = state_q;
		round_d = round_q;
		cmd = '0;
		cmd.round = round_q;
		in_ready = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			ST_KINIT: begin
				cmd.load_key = 1'b1;
				round_d = '0;
				state_d = ST_KEY;
			end
			ST_KEY: begin
				cfg_ready = 1'b1;
				if (cfg_valid) begin
					cmd.cfg_we = 1'b1;
					state_d = ST_KINIT;
				end else begin
					cmd.round_en = 1'b1;
					cmd.key_mode = 1'b1;
					round_d = round_q + 1'b1;
					if (round_q == sm4_pkg::LAST_ROUND) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready = !cfg_valid;
				round_d = '0;
				if (cfg_valid) begin
					cmd.cfg_we = 1'b1;
					state_d = ST_KINIT;
				end else if (in_valid) begin
					cmd.load_blk = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.round_en = 1'b1;
				round_d = round_q + 1'b1;
				if (round_q == sm4_pkg::LAST_ROUND) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_KINIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KINIT;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

endmodule

FILE: src/sm4_datapath.sv
module sm4_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sm4_pkg::sm4_cmd_t             cmd,
	output sm4_pkg::sm4_stat_t            stat,
	input  logic [sm4_pkg::KEY_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_decrypt,
	input  logic [31:0]                   in_word0,
	input  logic [31:0]                   in_word1,
	input  logic [31:0]                   in_word2,
	input  logic [31:0]                   in_word3,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   out_word0,
	output logic [31:0]                   out_word1,
	output logic [31:0]                   out_word2,
	output logic [31:0]                   out_word3,
	output logic                          ram_we,
	output logic [sm4_pkg::RK_AW-1:0]     ram_waddr,
	output logic [31:0]                   ram_wdata,
	output logic [sm4_pkg::RK_AW-1:0]     ram_raddr,
	input  logic [31:0]                   ram_rdata
);

	logic [31:0] key_q [4];
	logic [31:0] w_q [4];
	logic        dec_q;
	logic        out_valid_q;
	logic [31:0] out_q [4];
	logic [31:0] rk_in;
	logic [31:0] sb;
	logic [31:0] nw;
	logic [sm4_pkg::RK_AW-1:0] next_round;

	// shared round: key schedule uses ck and l', cipher uses round key and l
	always_comb begin
		rk_in = cmd.key_mode ? sm4_pkg::ck_word(cmd.round) : ram_rdata;
		sb = sm4_pkg::tau(w_q[1] ^ w_q[2] ^ w_q[3] ^ rk_in);
		nw = w_q[0] ^ (cmd.key_mode ? sm4_pkg::lin_key(sb) : sm4_pkg::lin_data(sb));
	end

	assign next_round = cmd.round + 1'b1;
	assign ram_we = cmd.round_en && cmd.key_mode;
	assign ram_waddr = cmd.round;
	assign ram_wdata = nw;
	// round key fetched in the cycle before its round, reversed index for decrypt
	assign ram_raddr = cmd.load_blk ? {sm4_pkg::RK_AW{in_decrypt}}
		: (next_round ^ {sm4_pkg::RK_AW{dec_q}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else if (cmd.cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			for (int i = 0; i < 4; i++) begin
				w_q[i] <= key_q[i] ^ sm4_pkg::FK[i];
			end
		end else if (cmd.load_blk) begin
			w_q[0] <= in_word0;
			w_q[1] <= in_word1;
			w_q[2] <= in_word2;
			w_q[3] <= in_word3;
			dec_q <= in_decrypt;
		end else if (cmd.round_en) begin
			w_q[0] <= w_q[1];
			w_q[1] <= w_q[2];
			w_q[2] <= w_q[3];
			w_q[3] <= nw;
		end
		if (cmd.out_load) begin
			out_q[0] <= w_q[3];
			out_q[1] <= w_q[2];
			out_q[2] <= w_q[1];
			out_q[3] <= w_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_word0 = out_q[0];
	assign out_word1 = out_q[1];
	assign out_word2 = out_q[2];
	assign out_word3 = out_q[3];

endmodule

FILE: src/sm4_block_cipher.sv
// SM4 block cipher, 128-bit key and block, one round per clock.
// cfg channel: a beat writes key word <index> (0 most significant). Every
// beat restarts the key schedule, which fills the 32-word round key RAM;
// no block is taken meanwhile.
// in_ch: one beat carries a block (in_word0..3) and the decrypt flag.
// out_ch: one beat carries the result, out_word0 = X35 .. out_word3 = X32.
// Result path: the block is loaded into the round registers and runs the 32
// rounds, then waits until the output register is free and is loaded into
// it; the first round key is fetched in the cycle of the input beat.
// Blocks are processed one at a time, as there is a single shared round
// unit and a single RAM read port.
// The output register frees the engine: a new block is taken while a
// result still waits; if the receiver stalls, the next finished block
// holds in the engine until the register drains.
// Reset: all key words clear to zero and the key schedule for the zero key
// runs at once, so in_ch ready stays low until it has finished.
`include "sm4_block_cipher_defines.svh"

module sm4_block_cipher (
	input  logic       clk,
	input  logic       arst_n,
	sm4_in_if.sink     in_ch,
	sm4_out_if.source  out_ch,
	sm4_cfg_if.sink    cfg
);

	sm4_pkg::sm4_cmd_t         cmd;
	sm4_pkg::sm4_stat_t        stat;
	logic                      ram_we;
	logic [sm4_pkg::RK_AW-1:0] ram_waddr;
	logic [31:0]               ram_wdata;
	logic [sm4_pkg::RK_AW-1:0] ram_raddr;
	logic [31:0]               ram_rdata;
	logic                      in_acc;
	logic                      cfg_acc;

	sm4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sm4_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.in_decrypt (in_ch.decrypt),
		.in_word0   (in_ch.in_word0),
		.in_word1   (in_ch.in_word1),
		.in_word2   (in_ch.in_word2),
		.in_word3   (in_ch.in_word3),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_word0  (out_ch.out_word0),
		.out_word1  (out_ch.out_word1),
		.out_word2  (out_ch.out_word2),
		.out_word3  (out_ch.out_word3),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	sm4_ram #(
		.WIDTH (32),
		.DEPTH (sm4_pkg::ROUND_COUNT)
	) u_rk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg_acc = cfg.valid && cfg.ready;

	`SM4_ASSERT_NOW(a_no_dual_accept, in_acc, !cfg_acc)
	`SM4_ASSERT_NEXT(a_busy_after_block, in_acc, !in_ch.ready)
	`SM4_ASSERT_NEXT(a_key_sched_after_write, cfg_acc, !in_ch.ready && !ram_we)

endmodule

FILE: test/sm4_block_cipher_tb.sv
module sm4_block_cipher_tb;

	localparam int LIMIT       = 1000000;
	localparam int ROUNDS      = 32;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 248;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN       = 4;
	localparam int TAIL        = 40;
	localparam int NDIR        = 30;

	typedef logic [sm4_pkg::KEY_IDX_W-1:0] key_idx_t;
	typedef logic [127:0] block_t;

	localparam key_idx_t KEY_W0 = 0;
	localparam key_idx_t KEY_W1 = 1;
	localparam key_idx_t KEY_W2 = 2;
	localparam key_idx_t KEY_W3 = 3;

	typedef enum logic {ROW_KEY, ROW_BLOCK} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		key_idx_t    idx;
		logic        dec;
		block_t      blk;
		logic [31:0] kval;
		logic        known;
		block_t      want;
	} stim_row_t;

	localparam logic [0:255][7:0] SUBST = {
		128'hD690E9FECCE13DB716B614C228FB2C05, 128'h2B679A762ABE04C3AA44132649860699,
		128'h9C4250F491EF987A33540B43EDCFAC62, 128'hE4B31CA9C908E89580DF94FA758F3FA6,
		128'h4707A7FCF37317BA83593C19E6854FA8, 128'h686B81B27164DA8BF8EB0F4B70569D35,
		128'h1E240E5E6358D1A225227C3B01217887, 128'hD40046579FD327524C3602E7A0C4C89E,
		128'hEABF8AD240C738B5A3F7F2CEF96115A1, 128'hE0AE5DA49B341A55AD933230F58CB1E3,
		128'h1DF6E22E8266CA60C02923AB0D534E6F, 128'hD5DB3745DEFD8E2F03FF6A726D6C5B51,
		128'h8D1BAF92BBDDBC7F11D95C411F105AD8, 128'h0AC13188A5CD7BBD2D74D012B8E5B4B0,
		128'h8969974A0C96777E65B9F109C56EC684, 128'h18F07DEC3ADC4D2079EE5F3ED7CB3948
	};

	localparam logic [0:3][31:0] FK_WORDS = {
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [0:31][31:0] CK_WORDS = {
		32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
		32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
		32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
		32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
		32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
		32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
		32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
		32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
	};

	localparam block_t STD_PT = 128'h01234567_89abcdef_fedcba98_76543210;
	localparam block_t STD_CT = 128'h681edf34_d206965e_86b3e94f_536e4246;

	localparam stim_row_t DIRECTED [NDIR] = '{
		'{ROW_BLOCK, KEY_W0, 1'b0, '0, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b0, '1, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b1, '0, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b1, '1, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b0, 128'h80000000_00000000_00000000_00000001,
			32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b1, 128'h00000001_80000000_00000001_80000000,
			32'h0, 1'b0, '0},
		'{ROW_KEY, KEY_W0, 1'b0, '0, 32'h01234567, 1'b0, '0},
		'{ROW_KEY, KEY_W1, 1'b0, '0, 32'h89abcdef, 1'b0, '0},
		'{ROW_KEY, KEY_W2, 1'b0, '0, 32'hfedcba98, 1'b0, '0},
		'{ROW_KEY, KEY_W3, 1'b0, '0, 32'h76543210, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b0, STD_PT, 32'h0, 1'b1, STD_CT},
		'{ROW_BLOCK, KEY_W0, 1'b1, STD_CT, 32'h0, 1'b1, STD_PT},
		'{ROW_BLOCK, KEY_W0, 1'b0, '0, 32'h0, 1'b0, '0},
		// only one key word rewritten, the others stay
		'{ROW_KEY, KEY_W1, 1'b0, '0, 32'h00000000, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b0, STD_PT, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b1, '1, 32'h0, 1'b0, '0},
		'{ROW_KEY, KEY_W0, 1'b0, '0, 32'hffffffff, 1'b0, '0},
		'{ROW_KEY, KEY_W1, 1'b0, '0, 32'hffffffff, 1'b0, '0},
		'{ROW_KEY, KEY_W2, 1'b0, '0, 32'hffffffff, 1'b0, '0},
		'{ROW_KEY, KEY_W3, 1'b0, '0, 32'hffffffff, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b0, '0, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b0, '1, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b1, '0, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b1, '1, 32'h0, 1'b0, '0},
		'{ROW_KEY, KEY_W0, 1'b0, '0, 32'h00000000, 1'b0, '0},
		'{ROW_KEY, KEY_W1, 1'b0, '0, 32'h00000000, 1'b0, '0},
		'{ROW_KEY, KEY_W2, 1'b0, '0, 32'h00000000, 1'b0, '0},
		'{ROW_KEY, KEY_W3, 1'b0, '0, 32'h00000000, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b0, STD_PT, 32'h0, 1'b0, '0},
		'{ROW_BLOCK, KEY_W0, 1'b1, 128'haaaaaaaa_55555555_aaaaaaaa_55555555,
			32'h0, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	sm4_in_if  in_ch();
	sm4_out_if out_ch();
	sm4_cfg_if cfg();

	sm4_block_cipher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	logic [31:0] key_regs [4];
	logic [31:0] round_keys [ROUNDS];
	block_t      cipher_expect [$];
	block_t      last_out;
	logic        last_dec;
	bit          no_idle;
	bit          hold_request;
	int          cycle_count;
	int          mismatches;
	int          enc_count;
	int          dec_count;
	int          key_writes;
	int          beats_seen;

	function automatic logic [31:0] rol32(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] subst_word(logic [31:0] v);
		return {SUBST[v[31:24]], SUBST[v[23:16]], SUBST[v[15:8]], SUBST[v[7:0]]};
	endfunction

	task automatic expand_round_keys();
		logic [31:0] k [4];
		logic [31:0] b;
		logic [31:0] rk;
		for (int i = 0; i < 4; i++)
			k[i] = key_regs[i] ^ FK_WORDS[i];
		for (int i = 0; i < ROUNDS; i++) begin
			b = subst_word(k[1] ^ k[2] ^ k[3] ^ CK_WORDS[i]);
			rk = k[0] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
			round_keys[i] = rk;
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = rk;
		end
	endtask

	function automatic block_t sm4_crypt(logic dec, block_t blk);
		logic [31:0] x [4];
		logic [31:0] b;
		logic [31:0] rk;
		logic [31:0] nx;
		for (int i = 0; i < 4; i++)
			x[i] = blk[127-32*i -: 32];
		for (int i = 0; i < ROUNDS; i++) begin
			rk = dec ? round_keys[ROUNDS-1-i] : round_keys[i];
			b = subst_word(x[1] ^ x[2] ^ x[3] ^ rk);
			nx = x[0] ^ b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		return {x[3], x[2], x[1], x[0]};
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic write_key(key_idx_t idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (cfg.ready !== 1'b1)
			@(posedge clk);
		cfg.valid <= 1'b0;
		key_regs[idx] = val;
		expand_round_keys();
		key_writes++;
		@(posedge clk);
	endtask

	task automatic wait_quiet();
		in_ch.valid <= 1'b0;
		while (cipher_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic send_block(logic dec, block_t blk, logic known, block_t want);
		int     gap;
		block_t result_blk;
		gap = draw_gap();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.decrypt <= dec;
		{in_ch.in_word0, in_ch.in_word1, in_ch.in_word2, in_ch.in_word3} <= blk;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		result_blk = known ? want : sm4_crypt(dec, blk);
		cipher_expect.push_back(result_blk);
		last_out = result_blk;
		last_dec = dec;
		if (dec)
			dec_count++;
		else
			enc_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, cipher_expect.size());
			$display("sm4_block_cipher_tb: errors");
			$finish;
		end
	end

	// result side
	initial begin
		int     stall;
		block_t got;
		block_t want;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = draw_gap();
				if (stall != 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (out_ch.valid !== 1'b1)
				@(posedge clk);
			got = {out_ch.out_word0, out_ch.out_word1, out_ch.out_word2, out_ch.out_word3};
			beats_seen++;
			if (cipher_expect.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing pending, expected none, got %h",
					$time, got);
			end else begin
				want = cipher_expect.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[127-32*i -: 32] !== want[127-32*i -: 32]) begin
						mismatches++;
						$display("%0t: out_word%0d expected %h got %h", $time, i,
							want[127-32*i -: 32], got[127-32*i -: 32]);
					end
			end
		end
	end

	// stimulus side
	initial begin
		logic   dec;
		block_t blk;
		int     sel;
		key_idx_t idx;
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.decrypt <= 1'b0;
		{in_ch.in_word0, in_ch.in_word1, in_ch.in_word2, in_ch.in_word3} <= '0;
		cfg.valid     <= 1'b0;
		cfg.index     <= KEY_W0;
		cfg.data      <= '0;
		no_idle       = 1'b0;
		hold_request  = 1'b0;
		last_out      = '0;
		last_dec      = 1'b0;
		for (int i = 0; i < 4; i++)
			key_regs[i] = '0;
		expand_round_keys();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NDIR; r++) begin
			if (DIRECTED[r].kind == ROW_KEY) begin
				wait_quiet();
				write_key(DIRECTED[r].idx, DIRECTED[r].kval);
			end else begin
				send_block(DIRECTED[r].dec, DIRECTED[r].blk, DIRECTED[r].known,
					DIRECTED[r].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			no_idle = (p % 3 == 1);
			case (p % 4)
				0: begin
					for (int i = 0; i < 4; i++)
						write_key(key_idx_t'(i), $urandom());
				end
				1: begin
					for (int i = 0; i < 4; i++)
						write_key(key_idx_t'(i), (p < 4) ? 32'hffffffff : 32'h0);
				end
				2: begin
					idx = key_idx_t'($urandom_range(0, 3));
					write_key(idx, $urandom());
				end
				default: begin
					write_key(KEY_W0, $urandom());
					write_key(KEY_W3, $urandom());
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stall the result side long enough for the input to back up
				if (n == 40 && (p == 0 || p == 5))
					hold_request = 1'b1;
				if (n == 120 && p == 2)
					wait_quiet();
				sel = $urandom_range(0, 9);
				dec = 1'($urandom_range(0, 1));
				case (sel)
					0: blk = '0;
					1: blk = '1;
					2: blk = block_t'(1) << $urandom_range(0, 127);
					3, 4, 5: begin
						// undo the previous block
						dec = ~last_dec;
						blk = last_out;
					end
					default: blk = {$urandom(), $urandom(), $urandom(), $urandom()};
				endcase
				send_block(dec, blk, 1'b0, '0);
			end
		end

		wait_quiet();
		repeat (TAIL) @(posedge clk);
		$display("ran %0d blocks (%0d encrypt, %0d decrypt), %0d result beats, %0d key writes",
			enc_count + dec_count, enc_count, dec_count, beats_seen, key_writes);
		$display("keys: zero, reference, partial, all ones, random; %0d mismatches",
			mismatches);
		if (mismatches == 0 && cipher_expect.size() == 0) begin
			$display("sm4_block_cipher_tb: clean");
		end else begin
			$display("sm4_block_cipher_tb: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/sm4_pkg.sv
src/sm4_if.sv
src/sm4_ram.sv
src/sm4_ctrl.sv
src/sm4_datapath.sv
src/sm4_block_cipher.sv
test/sm4_block_cipher_tb.sv
